/* rtl/core/sync_length_frame_receiver_macros.svh */
// ---------------------------------------------------------------------------
// sync length frame receiver assertion macros
// shared check wrappers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_RECEIVER_MACROS_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every edge out of reset
`define SLFR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// condition must never be seen out of reset
`define SLFR_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define SLFR_ASSERT(lbl, prop, msg)
`define SLFR_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/core/slfr_pkg.sv */
// ---------------------------------------------------------------------------
// slfr_pkg
// shared constants and controller/datapath interface types
// ---------------------------------------------------------------------------
package slfr_pkg;

   localparam int FRAME_BYTES_DEF = 32;
   localparam int BYTE_W          = 8;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAF;

   // write address source for the frame store
   typedef enum logic [2:0] {
      SEL_SYNC1 = 3'd0,
      SEL_SYNC2 = 3'd1,
      SEL_FUNC  = 3'd2,
      SEL_LEN   = 3'd3,
      SEL_BODY  = 3'd4
   } addr_sel_type;

   typedef struct packed {
      logic         wr_en;
      addr_sel_type wr_sel;
      logic         load_len;
      logic         inc_count;
      logic         clr_rd;
      logic         rd_go;
   } cmd_type;

   typedef struct packed {
      logic sync_first;
      logic sync_second;
      logic byte_zero;
      logic len_big;
      logic body_full;
      logic rd_last;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/slfr_ram.sv */
// ---------------------------------------------------------------------------
// slfr_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module slfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/slfr_dpath.sv */
// ---------------------------------------------------------------------------
// slfr_dpath
// frame store, length and count registers, readout pointer and output stage
// ---------------------------------------------------------------------------
`include "sync_length_frame_receiver_macros.svh"

module slfr_dpath #(
   parameter int FRAME_BYTES = slfr_pkg::FRAME_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [slfr_pkg::BYTE_W-1:0] req_tdata,
   input  slfr_pkg::cmd_type           cmd,
   output slfr_pkg::status_type        sts,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [slfr_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                        rsp_tlast
);

   import slfr_pkg::*;

   localparam int AW = $clog2(FRAME_BYTES);
   localparam logic [BYTE_W-1:0] LenMax = BYTE_W'(FRAME_BYTES - 5);

   logic [AW-1:0]        len_ff, len_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                 valid_ff, valid_in;
   logic                 last_ff, last_in;
   logic [AW+BYTE_W-1:0] byte_ext;
   logic [AW-1:0]        body_addr;
   logic [AW-1:0]        end_addr;
   logic [AW-1:0]        wr_addr;

   assign byte_ext  = {{AW{1'b0}}, req_tdata};
   assign body_addr = AW'(4) + cnt_ff;
   assign end_addr  = AW'(4) + len_ff;

   always_comb begin
      unique case (cmd.wr_sel)
         SEL_SYNC1: wr_addr = AW'(0);
         SEL_SYNC2: wr_addr = AW'(1);
         SEL_FUNC:  wr_addr = AW'(2);
         SEL_LEN:   wr_addr = AW'(3);
         default:   wr_addr = body_addr;
      endcase
   end

   // status toward the controller
   always_comb begin
      sts.sync_first  = (req_tdata == SYNC_FIRST);
      sts.sync_second = (req_tdata == SYNC_SECOND);
      sts.byte_zero   = (req_tdata == '0);
      sts.len_big     = (req_tdata > LenMax);
      sts.body_full   = (cnt_ff == len_ff);
      sts.rd_last     = (rd_ptr_ff == end_addr);
      sts.out_free    = !valid_ff || rsp_tready;
   end

   always_comb begin
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      rd_ptr_in = rd_ptr_ff;
      valid_in  = valid_ff;
      last_in   = last_ff;
      if (cmd.load_len) begin
         len_in = byte_ext[AW-1:0];
         cnt_in = '0;
      end else if (cmd.inc_count) begin
         cnt_in = cnt_ff + AW'(1);
      end
      if (cmd.clr_rd) begin
         rd_ptr_in = '0;
      end else if (cmd.rd_go) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
      // output stage: refill on a read, drop when taken
      if (cmd.rd_go) begin
         valid_in = 1'b1;
         last_in  = sts.rd_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         cnt_ff    <= '0;
         rd_ptr_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         rd_ptr_ff <= rd_ptr_in;
         valid_ff  <= valid_in;
      end
      last_ff <= last_in;
   end

   slfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (cmd.rd_go),
      .rd_addr (rd_ptr_ff),
      .rd_data (rsp_tdata)
   );

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;

   `SLFR_ASSERT(a_rd_in_frame, cmd.rd_go |-> rd_ptr_ff <= end_addr, "read past frame end")
   `SLFR_NEVER(a_len_range, len_ff > AW'(FRAME_BYTES - 5), "stored length too large")
   `SLFR_NEVER(a_rd_over_full, cmd.rd_go && valid_ff && !rsp_tready, "read over held word")

endmodule

/* rtl/core/slfr_ctrl.sv */
// ---------------------------------------------------------------------------
// slfr_ctrl
// frame parser state machine, drives the datapath commands
// ---------------------------------------------------------------------------
`include "sync_length_frame_receiver_macros.svh"

module slfr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  slfr_pkg::status_type sts,
   output slfr_pkg::cmd_type    cmd
);

   import slfr_pkg::*;

   typedef enum logic [5:0] {
      ST_HUNT1 = 6'b000001,
      ST_HUNT2 = 6'b000010,
      ST_FUNC  = 6'b000100,
      ST_LEN   = 6'b001000,
      ST_BODY  = 6'b010000,
      ST_DRAIN = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign req_tready = (state_ff != ST_DRAIN);
   assign take       = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      cmd.wr_en     = 1'b0;
      cmd.wr_sel    = SEL_BODY;
      cmd.load_len  = 1'b0;
      cmd.inc_count = 1'b0;
      cmd.clr_rd    = 1'b0;
      cmd.rd_go     = 1'b0;
      unique case (state_ff)
         ST_HUNT2: begin
            cmd.wr_sel = SEL_SYNC2;
            if (take && sts.sync_second) begin
               cmd.wr_en = 1'b1;
               state_in  = ST_FUNC;
            end
         end
         ST_FUNC: begin
            cmd.wr_sel = SEL_FUNC;
            if (take && !sts.byte_zero) begin
               cmd.wr_en = 1'b1;
               state_in  = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.wr_sel = SEL_LEN;
            if (take && !sts.byte_zero) begin
               if (sts.len_big) begin
                  state_in = ST_HUNT1;
               end else begin
                  cmd.wr_en    = 1'b1;
                  cmd.load_len = 1'b1;
                  state_in     = ST_BODY;
               end
            end
         end
         ST_BODY: begin
            if (take) begin
               cmd.wr_en = 1'b1;
               if (sts.body_full) begin
                  cmd.clr_rd = 1'b1;
                  state_in   = ST_DRAIN;
               end else begin
                  cmd.inc_count = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            cmd.rd_go = sts.out_free;
            if (sts.out_free && sts.rd_last) begin
               state_in = ST_HUNT1;
            end
         end
         default: begin
            cmd.wr_sel = SEL_SYNC1;
            if (take && sts.sync_first) begin
               cmd.wr_en = 1'b1;
               state_in  = ST_HUNT2;
            end else begin
               state_in = ST_HUNT1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT1;
      end else begin
         state_ff <= state_in;
      end
   end

   `SLFR_ASSERT(a_rd_only_drain, cmd.rd_go |-> state_ff == ST_DRAIN, "read outside drain")
   `SLFR_ASSERT(a_drain_from_body,
      (state_ff == ST_DRAIN && $past(state_ff) != ST_DRAIN) |-> $past(state_ff) == ST_BODY,
      "drain entered from wrong state")
   `SLFR_NEVER(a_no_write_drain, cmd.wr_en && state_ff == ST_DRAIN, "store written in drain")

endmodule

/* rtl/core/sync_length_frame_receiver.sv */
// ---------------------------------------------------------------------------
// sync_length_frame_receiver
// assembles 0xAA 0xAF func len payload checksum frames from a byte stream
// ---------------------------------------------------------------------------
// usage
//   req_ channel: one received byte per word in req_tdata
//   rsp_ channel: the whole frame, header first, one byte per word in
//   rsp_tdata, with rsp_tlast on the checksum byte
//   while parsing, req_tready is high and every input word is taken
//   after the checksum byte the frame is read out of the frame store, one
//   word per cycle while the sink does not stall, through the registered
//   ram read, whose register is also the output register; the first frame
//   word shows once the parser is in drain and its first read has returned
//   a frame holds 5+len bytes, and req_tready stays low until the last
//   read has been issued
//   a sink stall holds rsp_tdata and rsp_tlast steady and pauses the reads
//   a length above FRAME_BYTES-5 drops the frame silently and hunts again
//   reset returns the parser to sync hunting and empties the output stage;
//   the frame store needs no clearing, every byte sent was written that frame
// ---------------------------------------------------------------------------
module sync_length_frame_receiver #(
   parameter int FRAME_BYTES = slfr_pkg::FRAME_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // input bytes
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [slfr_pkg::BYTE_W-1:0] req_tdata,   // [7:0] rx_byte
   // frame bytes
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [slfr_pkg::BYTE_W-1:0] rsp_tdata,   // [7:0] frame_byte
   output logic                        rsp_tlast    // frame_last
);

   import slfr_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // parser sequencing
   slfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // frame store, counters and output register
   slfr_dpath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
